FILE: rtl/tknp_pkg.sv
// Shared types and constants for the k-nearest-points selector.
// Used by tknp_dist, tknp_cell and top_k_nearest_points_top; no dependencies.
package tknp_pkg;

    localparam int MAX_KEEP   = 16;
    localparam int CELL_IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int COORD_W    = 16;
    localparam int DIST_W     = 32;
    localparam int KEEP_W     = 5;
    localparam int PADDR_W    = 3;

    localparam logic [0:0] REG_KEEP_COUNT = 1'b0;

    typedef struct packed {
        logic                valid;
        logic                last;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [DIST_W-1:0]   sqdist;
    } point_t;

    typedef struct packed {
        logic                valid;
        logic                gt;
        logic [DIST_W-1:0]   sqdist;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
    } link_t;

    typedef struct packed {
        logic                insert;
        logic                grow;
        logic                drain;
        logic [DIST_W-1:0]   sqdist;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
    } ctrl_t;

    localparam link_t LINK_EMPTY = '0;

endpackage

FILE: rtl/tknp_dist.sv
// Squared-distance pipeline: magnitude, square, sum, one register per step.
// Depends on tknp_pkg.
module tknp_dist (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take,
    input  logic [tknp_pkg::COORD_W-1:0]    x,
    input  logic [tknp_pkg::COORD_W-1:0]    y,
    input  logic                            last_point,
    output tknp_pkg::point_t                point,
    output logic                            last_inflight
);
    import tknp_pkg::*;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic               s1_last_reg, s2_last_reg, s3_last_reg;
    logic [COORD_W-1:0] s1_x_reg, s1_y_reg, s2_x_reg, s2_y_reg, s3_x_reg, s3_y_reg;
    logic [COORD_W-1:0] s1_ax_reg, s1_ay_reg;
    logic [DIST_W-1:0]  s2_sqx_reg, s2_sqy_reg, s3_dist_reg;
    logic [COORD_W-1:0] ax_next, ay_next;

    always_comb
    begin
        ax_next = x[COORD_W-1] ? (~x + COORD_W'(1)) : x;
        ay_next = y[COORD_W-1] ? (~y + COORD_W'(1)) : y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= last_point;
        s1_x_reg    <= x;
        s1_y_reg    <= y;
        s1_ax_reg   <= ax_next;
        s1_ay_reg   <= ay_next;
        s2_last_reg <= s1_last_reg;
        s2_x_reg    <= s1_x_reg;
        s2_y_reg    <= s1_y_reg;
        s2_sqx_reg  <= {16'd0, s1_ax_reg} * {16'd0, s1_ax_reg};
        s2_sqy_reg  <= {16'd0, s1_ay_reg} * {16'd0, s1_ay_reg};
        s3_last_reg <= s2_last_reg;
        s3_x_reg    <= s2_x_reg;
        s3_y_reg    <= s2_y_reg;
        s3_dist_reg <= s2_sqx_reg + s2_sqy_reg;
    end

    always_comb
    begin
        point.valid   = s3_valid_reg;
        point.last    = s3_last_reg;
        point.x       = s3_x_reg;
        point.y       = s3_y_reg;
        point.sqdist  = s3_dist_reg;
        last_inflight = (s1_valid_reg && s1_last_reg) || (s2_valid_reg && s2_last_reg)
                        || (s3_valid_reg && s3_last_reg);
    end

endmodule

FILE: rtl/tknp_cell.sv
// One cell of the sorted chain: holds a kept point, inserts or shifts right.
// Depends on tknp_pkg.
module tknp_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  tknp_pkg::ctrl_t   ctrl,
    input  tknp_pkg::link_t   prev_link,
    input  logic              first,
    input  logic              next_valid,
    output tknp_pkg::link_t   link,
    output logic              tail_hit
);
    import tknp_pkg::*;

    logic               valid_reg, valid_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [COORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic               gt, prev_open, take_prev, take_new;

    always_comb
    begin
        gt        = valid_reg && (dist_reg > ctrl.sqdist);
        prev_open = first || prev_link.valid;
        take_prev = ctrl.drain || (ctrl.insert && prev_link.gt);
        take_new  = ctrl.insert && prev_open && !prev_link.gt && (!valid_reg || gt);

        if (ctrl.drain)
            valid_next = prev_link.valid;
        else if (ctrl.insert && ctrl.grow && prev_open)
            valid_next = 1'b1;
        else
            valid_next = valid_reg;

        if (take_prev)
        begin
            dist_next = prev_link.sqdist;
            x_next    = prev_link.x;
            y_next    = prev_link.y;
        end
        else if (take_new)
        begin
            dist_next = ctrl.sqdist;
            x_next    = ctrl.x;
            y_next    = ctrl.y;
        end
        else
        begin
            dist_next = dist_reg;
            x_next    = x_reg;
            y_next    = y_reg;
        end

        link.valid  = valid_reg;
        link.gt     = gt;
        link.sqdist = dist_reg;
        link.x      = x_reg;
        link.y      = y_reg;
        tail_hit    = valid_reg && !next_valid && gt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
    end

endmodule

FILE: rtl/top_k_nearest_points_top.sv
// Top level of the k-nearest-points selector: config port, chain and output.
// Depends on tknp_pkg, tknp_dist and tknp_cell.
//
// A point is taken at each clock edge where start is high and busy is low, so
// points stream in at one per cycle. The squared distance takes three register
// stages, and the point is written into the sorted chain of MAX_KEEP cells as
// it leaves the last of them. Once a point marked last_point is taken, busy
// stays high until the chain has drained: it shifts toward its far end once
// per cycle, and each kept point appears on the result ports for a single
// cycle with out_valid high, farthest first, the nearest one with last_out
// high. The receiver cannot stall, so it must take every result in that cycle.
// The final result shows in the first cycle with busy low. The user must
// write keep_count only while the block is idle; the block does not enforce it.
module top_k_nearest_points_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tknp_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [15:0]             x,
    input  logic signed [15:0]             y,
    input  logic                           last_point,
    output logic                           out_valid,
    output logic signed [15:0]             out_x,
    output logic signed [15:0]             out_y,
    output logic [31:0]                    out_distance,
    output logic                           last_out
);
    import tknp_pkg::*;

    logic [KEEP_W-1:0]     keep_count_reg;
    logic                  drain_reg, drain_next;
    logic                  out_valid_reg, last_out_reg;
    logic [COORD_W-1:0]    out_x_reg, out_y_reg;
    logic [DIST_W-1:0]     out_dist_reg;
    logic                  take, last_inflight, full, any_tail_hit, any_prev_valid;
    logic [CELL_IDX_W-1:0] eff_idx;
    point_t                point;
    ctrl_t                 ctrl;
    link_t                 links      [MAX_KEEP];
    link_t                 prev_links [MAX_KEEP];
    logic [MAX_KEEP-1:0]   next_valids, tail_hits, valid_vec, firsts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KEEP_COUNT) ? 32'(keep_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            keep_count_reg <= KEEP_W'(1);
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_KEEP_COUNT))
            keep_count_reg <= pwdata[KEEP_W-1:0];
    end

    assign take = start && !busy;
    assign busy = last_inflight || drain_reg;

    tknp_dist u_dist (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .x             (x),
        .y             (y),
        .last_point    (last_point),
        .point         (point),
        .last_inflight (last_inflight)
    );

    always_comb
    begin
        if (keep_count_reg == '0)
            eff_idx = '0;
        else if (32'(keep_count_reg) > 32'(MAX_KEEP))
            eff_idx = CELL_IDX_W'(MAX_KEEP - 1);
        else
            eff_idx = CELL_IDX_W'(keep_count_reg - KEEP_W'(1));

        for (int i = 0; i < MAX_KEEP; i++)
        begin
            valid_vec[i]   = links[i].valid;
            prev_links[i]  = (i == 0) ? LINK_EMPTY : links[(i == 0) ? 0 : i - 1];
            next_valids[i] = (i == MAX_KEEP - 1) ? 1'b0
                             : links[(i == MAX_KEEP - 1) ? i : i + 1].valid;
            firsts[i]      = (i == 0);
        end

        full           = valid_vec[eff_idx];
        any_tail_hit   = |tail_hits;
        any_prev_valid = 1'b0;
        for (int i = 0; i < MAX_KEEP; i++)
            any_prev_valid = any_prev_valid | prev_links[i].valid;

        ctrl.insert = point.valid && (!full || any_tail_hit);
        ctrl.grow   = !full;
        ctrl.drain  = drain_reg;
        ctrl.sqdist = point.sqdist;
        ctrl.x      = point.x;
        ctrl.y      = point.y;

        if (drain_reg)
            drain_next = any_prev_valid;
        else
            drain_next = point.valid && point.last;
    end

    for (genvar g = 0; g < MAX_KEEP; g++)
    begin : g_cell
        tknp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_link  (prev_links[g]),
            .first      (firsts[g]),
            .next_valid (next_valids[g]),
            .link       (links[g]),
            .tail_hit   (tail_hits[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            drain_reg     <= drain_next;
            out_valid_reg <= drain_reg && links[MAX_KEEP-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg    <= links[MAX_KEEP-1].x;
        out_y_reg    <= links[MAX_KEEP-1].y;
        out_dist_reg <= links[MAX_KEEP-1].sqdist;
        last_out_reg <= !prev_links[MAX_KEEP-1].valid;
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_distance = out_dist_reg;
    assign last_out     = out_valid_reg && last_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !drain_reg |-> $onehot({1'b0, valid_vec} + (MAX_KEEP + 1)'(1)))
        else $error("kept cells do not form a prefix of the chain");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(drain_reg && point.valid))
        else $error("point reached the chain while it was draining");

    assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg && !drain_next |=> valid_vec == '0)
        else $error("chain not empty after draining");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_out |=> !out_valid)
        else $error("result after the final item of a run");

endmodule
